@@ hdl/sts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, token codes and character classifiers for the token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_IDENT = 4'd1,
        MODE_INT   = 4'd2,
        MODE_OP    = 4'd3,
        MODE_SLASH = 4'd4,
        MODE_LINE  = 4'd5,
        MODE_BLOCK = 4'd6,
        MODE_BSTAR = 4'd7
    } t_mode;

    // token classes
    localparam logic [2:0] CLS_IDENT   = 3'd0;
    localparam logic [2:0] CLS_KEYWORD = 3'd1;
    localparam logic [2:0] CLS_INT     = 3'd2;
    localparam logic [2:0] CLS_OP      = 3'd3;
    localparam logic [2:0] CLS_SYMBOL  = 3'd4;
    localparam logic [2:0] CLS_COMMENT = 3'd5;
    localparam logic [2:0] CLS_ERROR   = 3'd6;

    // operator codes
    localparam logic [7:0] OP_INC   = 8'd0;
    localparam logic [7:0] OP_DEC   = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_SUB   = 8'd3;
    localparam logic [7:0] OP_MUL   = 8'd4;
    localparam logic [7:0] OP_DIV   = 8'd5;
    localparam logic [7:0] OP_MOD   = 8'd6;
    localparam logic [7:0] OP_POW   = 8'd7;
    localparam logic [7:0] OP_AND   = 8'd8;
    localparam logic [7:0] OP_OR    = 8'd9;
    localparam logic [7:0] OP_NOT   = 8'd10;
    localparam logic [7:0] OP_ASSIGN = 8'd11;
    localparam logic [7:0] OP_LT    = 8'd12;
    localparam logic [7:0] OP_GT    = 8'd13;
    localparam logic [7:0] OP_LE    = 8'd14;
    localparam logic [7:0] OP_GE    = 8'd15;
    localparam logic [7:0] OP_EQ    = 8'd16;
    localparam logic [7:0] OP_NE    = 8'd17;

    // comment kinds
    localparam logic [7:0] CMT_LINE  = 8'd0;
    localparam logic [7:0] CMT_BLOCK = 8'd1;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // keyword table: text right-aligned, first character in the top used byte
    localparam int KW_NUM   = 15;
    localparam int KW_CHARS = 8;
    localparam logic [63:0] KW_TEXT [KW_NUM] = '{
        64'("array"), 64'("boolean"), 64'("char"), 64'("else"), 64'("false"),
        64'("for"), 64'("function"), 64'("if"), 64'("integer"), 64'("print"),
        64'("return"), 64'("string"), 64'("true"), 64'("void"), 64'("while")
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd5, 4'd7, 4'd4, 4'd4, 4'd5, 4'd3, 4'd8, 4'd2,
        4'd7, 4'd5, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        return c == "+" || c == "-" || c == "&" || c == "|" ||
               c == "<" || c == ">" || c == "=" || c == "!";
    endfunction

    // {hit, code} of a two-character operator
    function automatic logic [8:0] pair_code(input logic [7:0] f, input logic [7:0] s);
        logic [8:0] r;
        r = '0;
        if (f == "+" && s == "+") r = {1'b1, OP_INC};
        else if (f == "-" && s == "-") r = {1'b1, OP_DEC};
        else if (f == "&" && s == "&") r = {1'b1, OP_AND};
        else if (f == "|" && s == "|") r = {1'b1, OP_OR};
        else if (f == "<" && s == "=") r = {1'b1, OP_LE};
        else if (f == ">" && s == "=") r = {1'b1, OP_GE};
        else if (f == "=" && s == "=") r = {1'b1, OP_EQ};
        else if (f == "!" && s == "=") r = {1'b1, OP_NE};
        return r;
    endfunction

    // {class, code} of a held operator that stands alone
    function automatic logic [10:0] single_op(input logic [7:0] c);
        logic [10:0] r;
        case (c)
            "+":     r = {CLS_OP, OP_ADD};
            "-":     r = {CLS_OP, OP_SUB};
            "!":     r = {CLS_OP, OP_NOT};
            "=":     r = {CLS_OP, OP_ASSIGN};
            "<":     r = {CLS_OP, OP_LT};
            ">":     r = {CLS_OP, OP_GT};
            default: r = {CLS_ERROR, c};
        endcase
        return r;
    endfunction

    // {class, code} of a character that is a whole token by itself
    function automatic logic [10:0] single_char(input logic [7:0] c);
        logic [10:0] r;
        case (c)
            "*":     r = {CLS_OP, OP_MUL};
            "%":     r = {CLS_OP, OP_MOD};
            "^":     r = {CLS_OP, OP_POW};
            ",":     r = {CLS_SYMBOL, 8'd0};
            ";":     r = {CLS_SYMBOL, 8'd1};
            ":":     r = {CLS_SYMBOL, 8'd2};
            "(":     r = {CLS_SYMBOL, 8'd3};
            ")":     r = {CLS_SYMBOL, 8'd4};
            "[":     r = {CLS_SYMBOL, 8'd5};
            "]":     r = {CLS_SYMBOL, 8'd6};
            "{":     r = {CLS_SYMBOL, 8'd7};
            "}":     r = {CLS_SYMBOL, 8'd8};
            default: r = {CLS_ERROR, c};
        endcase
        return r;
    endfunction

    // {class, code} of a finished name; prefix byte j sits at [8j+:8]
    function automatic logic [10:0] name_token(input logic [63:0] prefix,
                                               input logic [15:0] len);
        logic [10:0] r;
        logic        ok;
        r = {CLS_IDENT, 8'd0};
        for (int k = 0; k < KW_NUM; k++) begin
            if (len == 16'(KW_LEN[k])) begin
                ok = 1'b1;
                for (int j = 0; j < KW_CHARS; j++) begin
                    if (j < int'(KW_LEN[k])) begin
                        if (prefix[8*j +: 8] != KW_TEXT[k][8*(int'(KW_LEN[k])-1-j) +: 8])
                            ok = 1'b0;
                    end
                end
                if (ok) r = {CLS_KEYWORD, 8'(k)};
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/sts_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_front
// Scanner front end: classifies one character per valid cycle, tracks position
// and pending token, hands up to two finished tokens per character onward.
// ----------------------------------------------------------------------------
module sts_front #(
    parameter int LINE_BITS     = 16,
    parameter int COLUMN_BITS   = 12,
    parameter int LENGTH_BITS   = 8,
    parameter int KEYWORD_CHARS = 8,
    parameter int TOK_W         = 11 + LINE_BITS + COLUMN_BITS + LENGTH_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_char,
    input  logic                 i_final,
    output logic                 o_push,
    output logic [2*TOK_W:0]     o_bundle
);

    localparam int IW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

    sts_pkg::t_mode         r_mode,  n_mode;
    logic [7:0]             r_prefix [KEYWORD_CHARS];
    logic [7:0]             n_prefix [KEYWORD_CHARS];
    logic [LINE_BITS-1:0]   r_sline, n_sline, r_line, n_line;
    logic [COLUMN_BITS-1:0] r_scol, n_scol, r_col, n_col;
    logic [LENGTH_BITS-1:0] r_len, n_len, len_inc;
    logic [7:0]             r_pend, n_pend;

    logic                   a_vld, b_vld, c_vld, do_start;
    logic [TOK_W-1:0]       a_tok, b_tok, c_tok;
    logic [63:0]            r_flat, n_flat;
    logic [8:0]             pair;
    logic [10:0]            cc;

    function automatic logic [TOK_W-1:0] mk(input logic [10:0] cls_code,
                                            input logic [LINE_BITS-1:0] ln,
                                            input logic [COLUMN_BITS-1:0] col,
                                            input logic [LENGTH_BITS-1:0] len);
        return {len, col, ln, cls_code[7:0], cls_code[10:8]};
    endfunction

    // flatten the keyword-length part of the name prefix
    always_comb begin
        for (int j = 0; j < sts_pkg::KW_CHARS; j++) begin
            r_flat[8*j +: 8] = r_prefix[j];
            n_flat[8*j +: 8] = n_prefix[j];
        end
    end

    assign len_inc = (r_len == '1) ? r_len : r_len + 1'b1;
    assign pair    = sts_pkg::pair_code(r_pend, i_char);
    assign cc      = sts_pkg::single_char(i_char);

    // feed the character, start a new token, update position, flush on final
    always_comb begin
        n_mode   = r_mode;
        n_prefix = r_prefix;
        n_sline  = r_sline;
        n_scol   = r_scol;
        n_len    = r_len;
        n_pend   = r_pend;
        n_line   = r_line;
        n_col    = r_col;
        a_vld    = 1'b0;
        b_vld    = 1'b0;
        c_vld    = 1'b0;
        a_tok    = '0;
        b_tok    = '0;
        c_tok    = '0;
        do_start = 1'b0;

        case (r_mode)
            sts_pkg::MODE_IDENT: begin
                if (sts_pkg::is_name(i_char)) begin
                    if (r_len < LENGTH_BITS'(KEYWORD_CHARS))
                        n_prefix[r_len[IW-1:0]] = i_char;
                    n_len = len_inc;
                end else begin
                    a_vld    = 1'b1;
                    a_tok    = mk(sts_pkg::name_token(r_flat, 16'(r_len)), r_sline, r_scol,
                                  r_len);
                    do_start = 1'b1;
                end
            end
            sts_pkg::MODE_INT: begin
                if (sts_pkg::is_digit(i_char)) begin
                    n_len = len_inc;
                end else begin
                    a_vld    = 1'b1;
                    a_tok    = mk({sts_pkg::CLS_INT, 8'd0}, r_sline, r_scol, r_len);
                    do_start = 1'b1;
                end
            end
            sts_pkg::MODE_OP: begin
                a_vld = 1'b1;
                if (pair[8]) begin
                    a_tok  = mk({sts_pkg::CLS_OP, pair[7:0]}, r_sline, r_scol,
                                LENGTH_BITS'(2));
                    n_mode = sts_pkg::MODE_IDLE;
                end else begin
                    a_tok    = mk(sts_pkg::single_op(r_pend), r_sline, r_scol,
                                  LENGTH_BITS'(1));
                    do_start = 1'b1;
                end
            end
            sts_pkg::MODE_SLASH: begin
                if (i_char == sts_pkg::CH_SLASH) begin
                    n_len  = LENGTH_BITS'(2);
                    n_mode = sts_pkg::MODE_LINE;
                end else if (i_char == sts_pkg::CH_STAR) begin
                    n_len  = LENGTH_BITS'(2);
                    n_mode = sts_pkg::MODE_BLOCK;
                end else begin
                    a_vld    = 1'b1;
                    a_tok    = mk({sts_pkg::CLS_OP, sts_pkg::OP_DIV}, r_sline, r_scol,
                                  LENGTH_BITS'(1));
                    do_start = 1'b1;
                end
            end
            sts_pkg::MODE_LINE: begin
                n_len = len_inc;
                if (i_char == sts_pkg::CH_NL) begin
                    a_vld  = 1'b1;
                    a_tok  = mk({sts_pkg::CLS_COMMENT, sts_pkg::CMT_LINE}, r_sline, r_scol,
                                len_inc);
                    n_mode = sts_pkg::MODE_IDLE;
                end
            end
            sts_pkg::MODE_BLOCK: begin
                n_len = len_inc;
                if (i_char == sts_pkg::CH_STAR)
                    n_mode = sts_pkg::MODE_BSTAR;
            end
            sts_pkg::MODE_BSTAR: begin
                n_len = len_inc;
                if (i_char == sts_pkg::CH_SLASH) begin
                    a_vld  = 1'b1;
                    a_tok  = mk({sts_pkg::CLS_COMMENT, sts_pkg::CMT_BLOCK}, r_sline, r_scol,
                                len_inc);
                    n_mode = sts_pkg::MODE_IDLE;
                end else if (i_char != sts_pkg::CH_STAR) begin
                    n_mode = sts_pkg::MODE_BLOCK;
                end
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        // begin a token at this character
        if (do_start) begin
            n_mode = sts_pkg::MODE_IDLE;
            if (!sts_pkg::is_space(i_char)) begin
                n_sline = r_line;
                n_scol  = r_col;
                n_len   = LENGTH_BITS'(1);
                if (sts_pkg::is_alpha(i_char) || i_char == sts_pkg::CH_UNDER) begin
                    n_prefix[0] = i_char;
                    n_mode      = sts_pkg::MODE_IDENT;
                end else if (sts_pkg::is_digit(i_char)) begin
                    n_mode = sts_pkg::MODE_INT;
                end else if (i_char == sts_pkg::CH_SLASH) begin
                    n_mode = sts_pkg::MODE_SLASH;
                end else if (sts_pkg::is_op_start(i_char)) begin
                    n_pend = i_char;
                    n_mode = sts_pkg::MODE_OP;
                end else begin
                    b_vld = 1'b1;
                    b_tok = mk(cc, r_line, r_col, LENGTH_BITS'(1));
                end
            end
        end

        // advance position
        if (i_char == sts_pkg::CH_NL) begin
            n_col = '0;
            if (r_line != '1)
                n_line = r_line + 1'b1;
        end else if (r_col != '1) begin
            n_col = r_col + 1'b1;
        end

        // flush the pending token on the last character
        if (i_final) begin
            c_vld = 1'b1;
            case (n_mode)
                sts_pkg::MODE_IDENT:
                    c_tok = mk(sts_pkg::name_token(n_flat, 16'(n_len)), n_sline, n_scol,
                               n_len);
                sts_pkg::MODE_INT:
                    c_tok = mk({sts_pkg::CLS_INT, 8'd0}, n_sline, n_scol, n_len);
                sts_pkg::MODE_OP:
                    c_tok = mk(sts_pkg::single_op(n_pend), n_sline, n_scol,
                               LENGTH_BITS'(1));
                sts_pkg::MODE_SLASH:
                    c_tok = mk({sts_pkg::CLS_OP, sts_pkg::OP_DIV}, n_sline, n_scol,
                               LENGTH_BITS'(1));
                sts_pkg::MODE_LINE:
                    c_tok = mk({sts_pkg::CLS_COMMENT, sts_pkg::CMT_LINE}, n_sline, n_scol,
                               n_len);
                sts_pkg::MODE_BLOCK, sts_pkg::MODE_BSTAR:
                    c_tok = mk({sts_pkg::CLS_COMMENT, sts_pkg::CMT_BLOCK}, n_sline, n_scol,
                               n_len);
                default: c_vld = 1'b0;
            endcase
            n_mode = sts_pkg::MODE_IDLE;
            n_line = '0;
            n_col  = '0;
        end
    end

    // pack the results of this character: {two, second, first}
    always_comb begin
        o_push   = i_valid && (a_vld || b_vld || c_vld);
        o_bundle = '0;
        if (a_vld) begin
            o_bundle[TOK_W-1:0] = a_tok;
            if (b_vld || c_vld) begin
                o_bundle[2*TOK_W-1:TOK_W] = b_vld ? b_tok : c_tok;
                o_bundle[2*TOK_W]         = 1'b1;
            end
        end else begin
            o_bundle[TOK_W-1:0] = b_vld ? b_tok : c_tok;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sts_pkg::MODE_IDLE;
            r_sline <= '0;
            r_scol  <= '0;
            r_len   <= '0;
            r_pend  <= '0;
            r_line  <= '0;
            r_col   <= '0;
        end else if (i_valid) begin
            r_mode  <= n_mode;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_len   <= n_len;
            r_pend  <= n_pend;
            r_line  <= n_line;
            r_col   <= n_col;
        end
    end

    // name prefix bytes
    always_ff @(posedge i_clk) begin
        if (i_valid)
            r_prefix <= n_prefix;
    end

endmodule

@@ hdl/sts_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_queue
// Four-entry queue of token bundles between scanner front and output back.
// ----------------------------------------------------------------------------
module sts_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nempty,
    output logic [WIDTH-1:0] o_head
);

    logic [WIDTH-1:0] r_mem [4];
    logic [1:0]       r_wp, r_rp;
    logic [2:0]       r_cnt;

    assign o_full   = (r_cnt == 3'd4);
    assign o_nempty = (r_cnt != 3'd0);
    assign o_head   = r_mem[r_rp];

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_data;
    end

endmodule

@@ hdl/sts_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_back
// Output back end: splits queued bundles into single tokens and holds each
// in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module sts_back #(
    parameter int TOK_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_nempty,
    input  logic [2*TOK_W:0] i_head,
    output logic             o_pop,
    output logic             o_valid,
    output logic [TOK_W-1:0] o_tok,
    output logic             o_last,
    input  logic             i_ready
);

    logic             r_valid, r_last, r_idx, n_idx;
    logic [TOK_W-1:0] r_tok;
    logic             load, is_last;

    // pick the next token of the head bundle
    assign load    = i_nempty && (!r_valid || i_ready);
    assign is_last = !i_head[2*TOK_W] || r_idx;
    assign o_pop   = load && is_last;
    assign n_idx   = load ? !is_last : r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load)
                r_valid <= 1'b1;
            else if (i_ready)
                r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= r_idx ? i_head[2*TOK_W-1:TOK_W] : i_head[TOK_W-1:0];
            r_last <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

endmodule

@@ hdl/source_token_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_scanner
// Streaming lexical scanner: one source character in, tokens out by class,
// code, start position and length.
//
//   channel  dir  tdata (low bit up)                              tlast
//   s_axis   in   character[7:0]                                  final_req
//   m_axis   out  class, code, start line, start column, length   last_of_run
//
// One character is taken per cycle; each yields zero, one or two tokens, which
// leave one per ready cycle through the output register. A four-bundle queue
// decouples the two sides, so input stalls only when it fills.
// Reset (i_rst_n low, synchronous) returns the scanner to idle at line 0,
// column 0 and empties the queue.
// ----------------------------------------------------------------------------
module source_token_scanner #(
    parameter int LINE_BITS     = 16,
    parameter int COLUMN_BITS   = 12,
    parameter int LENGTH_BITS   = 8,
    parameter int KEYWORD_CHARS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // character[7:0]
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // token_class[2:0], token_code, start_line, start_column, token_length, zero pad
    output logic [((11 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0]
                                 m_axis_tdata,
    output logic                 m_axis_tlast
);

    localparam int TOK_W = 11 + LINE_BITS + COLUMN_BITS + LENGTH_BITS;
    localparam int OUT_W = ((TOK_W + 7) / 8) * 8;

    logic                 accept, push, full, nempty, pop;
    logic [2*TOK_W:0]     bundle, head;
    logic [TOK_W-1:0]     tok;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    sts_front #(
        .LINE_BITS    (LINE_BITS),
        .COLUMN_BITS  (COLUMN_BITS),
        .LENGTH_BITS  (LENGTH_BITS),
        .KEYWORD_CHARS(KEYWORD_CHARS),
        .TOK_W        (TOK_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_char  (s_axis_tdata),
        .i_final (s_axis_tlast),
        .o_push  (push),
        .o_bundle(bundle)
    );

    sts_queue #(
        .WIDTH(2 * TOK_W + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (bundle),
        .i_pop   (pop),
        .o_full  (full),
        .o_nempty(nempty),
        .o_head  (head)
    );

    sts_back #(
        .TOK_W(TOK_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_nempty(nempty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_tok   (tok),
        .o_last  (m_axis_tlast),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = OUT_W'(tok);

endmodule
